### hw/rtl/lpmr_pkg.sv
package lpmr_pkg;

   localparam int RING_BYTES = 4096;
   localparam int ADDR_W = $clog2(RING_BYTES);
   localparam int SPAN_W = ADDR_W + 1;
   localparam int LEN_W = 12;
   localparam int CNT_W = 10;
   localparam int LEFT_W = 13;

   localparam logic [SPAN_W-1:0] RING_SPAN = SPAN_W'(RING_BYTES);
   localparam logic [CNT_W-1:0] MAX_MSG_RESET = CNT_W'(512);

   localparam logic [1:0] MODE_OPEN = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_DEQ = 2'd2;
   localparam logic [1:0] MODE_PEEK = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_SPACE = 3'd1;
   localparam logic [2:0] ST_COUNT_LIMIT = 3'd2;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;
   localparam logic [2:0] ST_NONE_OPEN = 3'd5;
   localparam logic [2:0] ST_ALREADY_OPEN = 3'd6;

   typedef struct packed {
      logic [1:0] mode;
      logic [LEN_W-1:0] msg_length;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic last_byte;
      logic [2:0] status;
      logic [CNT_W-1:0] messages_held;
      logic is_empty;
      logic is_full;
   } result_type;

   function automatic logic [ADDR_W-1:0] align_up(input logic [ADDR_W-1:0] pos);
      logic [ADDR_W-1:0] p;
      p = pos + ADDR_W'(3);
      return {p[ADDR_W-1:2], 2'b00};
   endfunction

   function automatic logic [SPAN_W-1:0] free_span(input logic [ADDR_W-1:0] head,
                                                   input logic [ADDR_W-1:0] tail);
      logic [ADDR_W-1:0] d;
      d = head - tail;
      return (head == tail) ? RING_SPAN : {1'b0, d};
   endfunction

endpackage

### hw/rtl/lpmr_ram.sv
module lpmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/lpmr_front.sv
module lpmr_front
   import lpmr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     head_valid,
   output item_type head_item,
   input  logic     pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;

   assign push_ready = (fill_ff != 2'd2);
   assign push = push_valid && push_ready;
   assign head_valid = (fill_ff != 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/lpmr_back.sv
module lpmr_back
   import lpmr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  item_type         item,
   output logic             item_pop,
   input  logic [CNT_W-1:0] max_messages,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output result_type       rsp
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PFXW = 3'd1;
   localparam logic [2:0] S_PFX0 = 3'd2;
   localparam logic [2:0] S_PFX1 = 3'd3;
   localparam logic [2:0] S_DATA = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        pw_cnt_ff, pw_cnt_in;
   logic [7:0]        lo_ff, lo_in;
   logic [ADDR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] wcur_ff, wcur_in;
   logic [LEN_W-1:0]  wleft_ff, wleft_in;
   logic [ADDR_W-1:0] rcur_ff, rcur_in, pcur_ff, pcur_in;
   logic [LEFT_W-1:0] rleft_ff, rleft_in, pleft_ff, pleft_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;

   logic              finish;
   logic [7:0]        r_byte;
   logic              r_last;
   logic [2:0]        r_status;
   logic              is_deq;
   logic [ADDR_W-1:0] cur_sel, ncur;
   logic [LEFT_W-1:0] left_sel, nleft, pfx;
   logic [SPAN_W-1:0] free_now, free_next;

   lpmr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign is_deq = (item.mode == MODE_DEQ);
   assign cur_sel = is_deq ? rcur_ff : pcur_ff;
   assign left_sel = is_deq ? rleft_ff : pleft_ff;
   assign free_now = free_span(head_ff, tail_ff);

   always_comb begin
      state_in = state_ff;
      pw_cnt_in = pw_cnt_ff;
      lo_in = lo_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      wcur_in = wcur_ff;
      wleft_in = wleft_ff;
      rcur_in = rcur_ff;
      rleft_in = rleft_ff;
      pcur_in = pcur_ff;
      pleft_in = pleft_ff;
      ram_we = 1'b0;
      ram_waddr = tail_ff;
      ram_wdata = item.msg_length[7:0];
      ram_raddr = cur_sel;
      finish = 1'b0;
      r_byte = 8'd0;
      r_last = 1'b0;
      r_status = ST_OK;
      ncur = cur_sel + ADDR_W'(1);
      nleft = left_sel - LEFT_W'(1);
      pfx = {ram_rdata[4:0], lo_ff};
      case (state_ff)
         S_IDLE: begin
            if (item_valid && !rsp_valid_ff) begin
               case (item.mode)
                  MODE_OPEN: begin
                     if (wleft_ff != '0) begin
                        r_status = ST_ALREADY_OPEN;
                        finish = 1'b1;
                     end else if (item.msg_length == '0) begin
                        r_status = ST_BAD_LENGTH;
                        finish = 1'b1;
                     end else if (count_ff >= max_messages) begin
                        r_status = ST_COUNT_LIMIT;
                        finish = 1'b1;
                     end else if ({1'b0, item.msg_length} + SPAN_W'(8) > free_now) begin
                        r_status = ST_NO_SPACE;
                        finish = 1'b1;
                     end else begin
                        ram_we = 1'b1;
                        pw_cnt_in = 2'd1;
                        state_in = S_PFXW;
                     end
                  end
                  MODE_WRITE: begin
                     finish = 1'b1;
                     if (wleft_ff == '0) begin
                        r_status = ST_NONE_OPEN;
                     end else begin
                        ram_we = 1'b1;
                        ram_waddr = wcur_ff;
                        ram_wdata = item.data_byte;
                        wcur_in = wcur_ff + ADDR_W'(1);
                        wleft_in = wleft_ff - LEN_W'(1);
                        if (wleft_ff == LEN_W'(1)) begin
                           tail_in = align_up(wcur_in);
                           count_in = count_ff + CNT_W'(1);
                           r_last = 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (left_sel == '0) begin
                        if (count_ff == '0) begin
                           r_status = ST_EMPTY;
                           finish = 1'b1;
                        end else begin
                           ram_raddr = head_ff;
                           state_in = S_PFX0;
                        end
                     end else begin
                        state_in = S_DATA;
                     end
                  end
               endcase
            end
         end
         S_PFXW: begin
            ram_we = 1'b1;
            ram_waddr = tail_ff + ADDR_W'(pw_cnt_ff);
            ram_wdata = (pw_cnt_ff == 2'd1) ? {4'd0, item.msg_length[11:8]} : 8'd0;
            pw_cnt_in = pw_cnt_ff + 2'd1;
            if (pw_cnt_ff == 2'd3) begin
               wcur_in = tail_ff + ADDR_W'(4);
               wleft_in = item.msg_length;
               finish = 1'b1;
            end
         end
         S_PFX0: begin
            ram_raddr = head_ff + ADDR_W'(1);
            lo_in = ram_rdata;
            state_in = S_PFX1;
         end
         S_PFX1: begin
            ram_raddr = head_ff + ADDR_W'(4);
            if (pfx == '0) begin
               pfx = LEFT_W'(1);
            end
            if (is_deq) begin
               rcur_in = ram_raddr;
               rleft_in = pfx;
            end else begin
               pcur_in = ram_raddr;
               pleft_in = pfx;
            end
            state_in = S_DATA;
         end
         S_DATA: begin
            finish = 1'b1;
            r_byte = ram_rdata;
            if (is_deq) begin
               rcur_in = ncur;
               rleft_in = nleft;
            end else begin
               pcur_in = ncur;
               pleft_in = nleft;
            end
            if (nleft == '0) begin
               r_last = 1'b1;
               if (is_deq) begin
                  head_in = align_up(ncur);
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end
                  pleft_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         state_in = S_IDLE;
      end
   end

   assign free_next = free_span(head_in, tail_in);
   assign item_pop = finish;

   always_comb begin
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || finish;
      rsp_in = rsp_ff;
      if (finish) begin
         rsp_in.read_byte = r_byte;
         rsp_in.last_byte = r_last;
         rsp_in.status = r_status;
         rsp_in.messages_held = count_in;
         rsp_in.is_empty = (count_in == '0);
         rsp_in.is_full = (count_in >= max_messages) || (free_next < SPAN_W'(8));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         wcur_ff <= '0;
         wleft_ff <= '0;
         rcur_ff <= '0;
         rleft_ff <= '0;
         pcur_ff <= '0;
         pleft_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         wcur_ff <= wcur_in;
         wleft_ff <= wleft_in;
         rcur_ff <= rcur_in;
         rleft_ff <= rleft_in;
         pcur_ff <= pcur_in;
         pleft_ff <= pleft_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pw_cnt_ff <= pw_cnt_in;
      lo_ff <= lo_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

### hw/rtl/length_prefixed_message_ring_core.sv
// Message FIFO held in a 4096-byte ring, each message stored behind a 4-byte length prefix.
// Requests arrive on the req_ stream: tuser carries the operation (open, write byte,
// dequeue byte, peek byte) and tdata the message length and the data byte.
// Every request transfer produces exactly one response transfer on the rsp_ stream,
// carrying the returned byte, a status code, the message count and the empty and full flags;
// tlast marks the final byte of a message that is committed, dequeued or peeked.
// The csr_ channel writes the message-count limit; the user must write it only while the block
// is idle, and the block itself does not enforce this. Requests enter a two-entry queue and are
// executed one at a time by the back end. A write byte or a failed request is finished in the
// idle state; an open writes the four prefix bytes one after another into the byte-wide ring
// memory; a dequeue or peek reads its byte in the data state, and one that starts a new message
// first passes through the prefix-read states, because the prefix and the first byte are read
// one after another through the single registered read port. The back end starts a request
// only when the response register is empty, even when responses are taken at once.
// After reset the ring is empty, no message is open and the limit is 512.
// When the receiver stalls, the response is held and the queue fills, then req_tready falls.
module length_prefixed_message_ring_core
   import lpmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // msg_length[11:0], data_byte[19:12], zero fill
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // read_byte[7:0], status[10:8], messages_held[20:11],
                                   // is_empty[21], is_full[22], zero fill
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data
);

   logic [CNT_W-1:0] max_msg_ff, max_msg_in;
   item_type         in_item, head_item;
   logic             head_valid, pop;
   result_type       rsp;

   assign csr_ready = 1'b1;
   assign max_msg_in = (csr_valid && csr_ready) ? csr_data : max_msg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_msg_ff <= MAX_MSG_RESET;
      end else begin
         max_msg_ff <= max_msg_in;
      end
   end

   assign in_item.mode = req_tuser;
   assign in_item.msg_length = req_tdata[11:0];
   assign in_item.data_byte = req_tdata[19:12];

   lpmr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push_valid(req_tvalid),
      .push_ready(req_tready),
      .push_item (in_item),
      .head_valid(head_valid),
      .head_item (head_item),
      .pop       (pop)
   );

   lpmr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (head_valid),
      .item        (head_item),
      .item_pop    (pop),
      .max_messages(max_msg_ff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.is_full, rsp.is_empty, rsp.messages_held, rsp.status,
                       rsp.read_byte};
   assign rsp_tlast = rsp.last_byte;

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21] == (rsp_tdata[20:11] == 10'd0)))
      else $error("empty flag disagrees with message count");

   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[10:8] == ST_OK))
      else $error("last byte reported on a failed request");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("back end finished a request that was not queued");

   a_new_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_tvalid)
      else $error("finished request produced no response");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lpmr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = MODE_OPEN;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [9:0]  csr_data = '0;

   length_prefixed_message_ring_core u_dut (.*);

   always #6 clock = ~clock;

   localparam int SPAN = 4096;

   logic [7:0]  ring_mem [SPAN];
   int unsigned head_pos, tail_pos, held_count, msg_limit;
   int unsigned wr_pos, wr_left, rd_pos, rd_left, pk_pos, pk_left;

   result_type  expected_rsp [$];
   int          failures = 0;
   int          idle_pct = 32;
   bit          hold_rsp = 1'b0;

   function automatic int unsigned ring_wrap(int unsigned p);
      return (p >= SPAN) ? p - SPAN : p;
   endfunction

   function automatic int unsigned ring_align(int unsigned p);
      int unsigned q;
      q = (p + 3) & ~32'd3;
      return (q >= SPAN) ? 0 : q;
   endfunction

   function automatic int unsigned ring_free();
      if (head_pos <= tail_pos) return SPAN - (tail_pos - head_pos);
      return head_pos - tail_pos;
   endfunction

   function automatic result_type predict_ring(logic [1:0] mode, int unsigned len,
                                               logic [7:0] data);
      result_type r;
      bit is_deq;
      int unsigned cur, left;
      r = '0;
      r.status = ST_OK;
      if (mode == MODE_OPEN) begin
         if (wr_left != 0) r.status = ST_ALREADY_OPEN;
         else if (len == 0) r.status = ST_BAD_LENGTH;
         else if (held_count >= msg_limit) r.status = ST_COUNT_LIMIT;
         else if (len + 8 > ring_free()) r.status = ST_NO_SPACE;
         else begin
            for (int i = 0; i < 4; i++) ring_mem[tail_pos + i] = 8'(len >> (8 * i));
            wr_pos = ring_wrap(tail_pos + 4);
            wr_left = len;
         end
      end else if (mode == MODE_WRITE) begin
         if (wr_left == 0) r.status = ST_NONE_OPEN;
         else begin
            ring_mem[wr_pos] = data;
            wr_pos = ring_wrap(wr_pos + 1);
            wr_left--;
            if (wr_left == 0) begin
               tail_pos = ring_align(wr_pos);
               held_count++;
               r.last_byte = 1'b1;
            end
         end
      end else begin
         is_deq = (mode == MODE_DEQ);
         cur = is_deq ? rd_pos : pk_pos;
         left = is_deq ? rd_left : pk_left;
         if (left == 0) begin
            if (held_count == 0) r.status = ST_EMPTY;
            else begin
               left = 0;
               for (int i = 3; i >= 0; i--)
                  left = (left << 8) | ring_mem[(head_pos + i) % SPAN];
               left &= 32'h1FFF;
               cur = ring_wrap(head_pos + 4);
               if (left == 0) left = 1;
            end
         end
         if (r.status == ST_OK) begin
            r.read_byte = ring_mem[cur];
            cur = ring_wrap(cur + 1);
            left--;
            if (left == 0) begin
               r.last_byte = 1'b1;
               if (is_deq) begin
                  head_pos = ring_align(cur);
                  if (held_count > 0) held_count--;
                  pk_left = 0;
               end
            end
         end
         if (is_deq) begin
            rd_pos = cur;
            rd_left = left;
         end else begin
            pk_pos = cur;
            pk_left = left;
         end
      end
      r.messages_held = CNT_W'(held_count);
      r.is_empty = (held_count == 0);
      r.is_full = (held_count >= msg_limit) || (ring_free() < 8);
      return r;
   endfunction

   task automatic send_request(logic [1:0] mode, logic [11:0] len, logic [7:0] data);
      while (($urandom_range(99) < idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {4'b0, data, len};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsp.push_back(predict_ring(mode, len, data));
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned value);
      drain_and_settle();
      csr_valid <= 1'b1;
      csr_data <= 10'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      msg_limit = value;
   endtask

   task automatic put_message(int unsigned len);
      send_request(MODE_OPEN, 12'(len), 8'($urandom));
      for (int i = 0; i < len; i++) send_request(MODE_WRITE, 12'($urandom), 8'($urandom));
   endtask

   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_byte = rsp_tdata[7:0];
         got.status = rsp_tdata[10:8];
         got.messages_held = rsp_tdata[20:11];
         got.is_empty = rsp_tdata[21];
         got.is_full = rsp_tdata[22];
         got.last_byte = rsp_tlast;
         if (expected_rsp.size() == 0) begin
            $error("response transfer with nothing expected");
            failures++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.read_byte !== want.read_byte) begin
               $error("read_byte expected %0h got %0h", want.read_byte, got.read_byte);
               failures++;
            end
            if (got.last_byte !== want.last_byte) begin
               $error("last_byte expected %0d got %0d", want.last_byte, got.last_byte);
               failures++;
            end
            if (got.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, got.status);
               failures++;
            end
            if (got.messages_held !== want.messages_held) begin
               $error("messages_held expected %0d got %0d",
                      want.messages_held, got.messages_held);
               failures++;
            end
            if (got.is_empty !== want.is_empty) begin
               $error("is_empty expected %0d got %0d", want.is_empty, got.is_empty);
               failures++;
            end
            if (got.is_full !== want.is_full) begin
               $error("is_full expected %0d got %0d", want.is_full, got.is_full);
               failures++;
            end
         end
      end
   end

   task automatic test_special_cases();
      send_request(MODE_DEQ, 12'hFFF, 8'hFF);
      send_request(MODE_PEEK, 12'd0, 8'd0);
      send_request(MODE_WRITE, 12'd0, 8'hA5);
      send_request(MODE_OPEN, 12'd0, 8'd0);
      send_request(MODE_OPEN, 12'd4089, 8'd0);
      send_request(MODE_OPEN, 12'd2, 8'd0);
      send_request(MODE_OPEN, 12'd3, 8'd0);
      send_request(MODE_WRITE, 12'hFFF, 8'h00);
      send_request(MODE_WRITE, 12'd0, 8'hFF);
      put_message(1);
      send_request(MODE_PEEK, 12'd0, 8'd0);
      send_request(MODE_PEEK, 12'd0, 8'd0);
      send_request(MODE_DEQ, 12'd0, 8'd0);
      send_request(MODE_PEEK, 12'd0, 8'd0);
      send_request(MODE_DEQ, 12'd0, 8'd0);
      send_request(MODE_DEQ, 12'd0, 8'd0);
      send_request(MODE_DEQ, 12'd0, 8'd0);
      send_request(MODE_DEQ, 12'd0, 8'd0);
   endtask

   task automatic test_count_limit();
      write_limit(0);
      send_request(MODE_OPEN, 12'd5, 8'd0);
      write_limit(1);
      put_message(2);
      send_request(MODE_OPEN, 12'd5, 8'd0);
      write_limit(1023);
      put_message(3);
      while (held_count != 0) send_request(MODE_DEQ, 12'd0, 8'd0);
   endtask

   task automatic test_space_limit();
      put_message(1);
      send_request(MODE_OPEN, 12'd4088, 8'd0);
      while (held_count != 0) send_request(MODE_DEQ, 12'd0, 8'd0);
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (30) send_request(MODE_PEEK, 12'd0, 8'd0);
      join
   endtask

   task automatic test_random_traffic();
      int unsigned pick;
      bit limit_low, limit_back;
      limit_low = 1'b0;
      limit_back = 1'b0;
      for (int n = 0; n < 720; ) begin
         idle_pct = (n >= 300 && n < 450) ? 0 : 32;
         if (n >= 500 && !limit_low) begin
            write_limit(3);
            limit_low = 1'b1;
         end
         if (n >= 650 && !limit_back) begin
            write_limit(512);
            limit_back = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 40) begin
            pick = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 12);
            if (pick > 200) begin
               send_request(MODE_OPEN, 12'(pick), 8'd0);
               n++;
            end else begin
               put_message(pick);
               n += pick + 1;
            end
         end else if (pick < 75) begin
            send_request(MODE_DEQ, 12'($urandom), 8'($urandom));
            n++;
         end else if (pick < 92) begin
            send_request(MODE_PEEK, 12'($urandom), 8'($urandom));
            n++;
         end else begin
            send_request(2'($urandom), 12'($urandom_range(0, 20)), 8'($urandom));
            n++;
         end
      end
      idle_pct = 32;
   endtask

   initial begin
      msg_limit = 512;
      head_pos = 0; tail_pos = 0; held_count = 0;
      wr_pos = 0; wr_left = 0; rd_pos = 0; rd_left = 0; pk_pos = 0; pk_left = 0;
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_count_limit();
      test_space_limit();
      test_backpressure();
      test_random_traffic();
      drain_and_settle();
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
